FILE: hw/rtl/rtcep_pkg.sv
// Shared constants and helper functions for the RTC snapshot to epoch converter.
package rtcep_pkg;

   localparam int unsigned RAW_W        = 8;
   localparam int unsigned YEAR_W       = 15;
   localparam int unsigned CUR_YEAR_W   = 14;
   localparam int unsigned CENT_W       = 8;
   localparam int unsigned QCENT_W      = 9;
   localparam int unsigned EPOCH_W      = 40;
   localparam int unsigned DAYS_W       = 24;
   localparam int unsigned FRAC_W       = 13;
   localparam int unsigned MDAYS_W      = 9;
   localparam int unsigned HMS_W        = 20;
   localparam int unsigned CSR_INDEX_W  = 2;
   localparam int unsigned PIPE_LATENCY = 5;

   // Status register B bits and the PM flag of the hour byte.
   localparam int unsigned STB_BINARY_BIT = 2;
   localparam int unsigned STB_24H_BIT    = 1;
   localparam int unsigned HOUR_PM_BIT    = 7;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTURY_IN_USE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUR_YEAR       = 2'd1;

   localparam int unsigned CUR_YEAR_RESET_VAL = 2024;
   localparam int unsigned CUR_CENT_RESET_VAL = CUR_YEAR_RESET_VAL / 100;
   localparam logic [CUR_YEAR_W-1:0] CUR_YEAR_RESET = CUR_YEAR_W'(CUR_YEAR_RESET_VAL);
   localparam logic [CENT_W-1:0]     CUR_CENT_RESET = CENT_W'(CUR_CENT_RESET_VAL);

   localparam logic [YEAR_W-1:0] EPOCH_YEAR = 15'd1970;

   // Division by 100 as a reciprocal multiply; exact for values below 43699.
   localparam logic [12:0]  DIV100_MUL   = 13'd5243;
   localparam int unsigned  DIV100_SHIFT = 19;

   // The fractional part of 365.2422 days per year, 0.2422 scaled by 2^30 and
   // rounded up. The rounding error stays far below the 1/5000 step of the
   // exact quotient for every 15 bit year count, so the floor is exact.
   localparam int unsigned     YEAR_FRAC_SHIFT = 30;
   localparam longint unsigned YEAR_FRAC_MUL_L =
      ((64'd2422 << YEAR_FRAC_SHIFT) + 64'd9999) / 64'd10000;
   localparam logic [27:0]     YEAR_FRAC_MUL   = 28'(YEAR_FRAC_MUL_L);

   localparam logic [DAYS_W-1:0] DAYS_PER_YEAR = 24'd365;
   localparam logic [16:0]       SEC_PER_DAY   = 17'd86400;

   // Packed BCD byte to binary: low nibble plus ten times the high nibble.
   function automatic logic [RAW_W-1:0] bcd8(input logic [RAW_W-1:0] v);
      return RAW_W'(v[3:0]) + RAW_W'(v[7:4]) * 8'd10;
   endfunction

   // Hour byte from BCD: bit 7 is the PM flag and is kept as it is.
   function automatic logic [RAW_W-1:0] bcd_hour(input logic [RAW_W-1:0] v);
      logic [6:0] low;
      low = 7'(v[3:0]) + 7'(v[6:4]) * 7'd10;
      return {v[HOUR_PM_BIT], low};
   endfunction

   // Remainder by 24 for values up to 139, by at most five subtractions.
   function automatic logic [RAW_W-1:0] mod24(input logic [RAW_W-1:0] x);
      logic [RAW_W-1:0] r;
      r = x;
      for (int i = 0; i < 5; i++) begin
         if (r >= 8'd24) begin
            r = r - 8'd24;
         end
      end
      return r;
   endfunction

   // Days in the months before month m of a common year.
   function automatic logic [MDAYS_W-1:0] cum_days(input logic [3:0] m);
      logic [MDAYS_W-1:0] d;
      unique case (m)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

FILE: hw/rtl/rtc_fields_to_epoch_seconds.sv
// Top level: pipelined conversion of an RTC register snapshot to seconds since 1970.
//
// A request carries one snapshot of the clock register bytes and status register B.
// A request is accepted at a rising edge where start is high and busy is low; busy
// is high only while reset is held, so one request can enter in every cycle.
// Each result is shown for exactly one cycle with rsp_valid high; the receiver
// cannot hold it off, and nothing in the pipeline ever waits on it.
// A request accepted at a rising edge passes through the stage registers s1 to s4 and
// the output registers before rsp_valid rises. Throughput: one request per cycle.
// The five stages are BCD decode and year, three parallel constant multiplies plus
// time of day, day count with leap correction, days times 86400, and the final sum.
// The configuration channel (csr_valid, csr_ready, csr_index, csr_data) writes
// century_in_use (index 0) and the current year (index 1); the user must write it
// only while no request is in flight; the block does not enforce this.
// csr_ready is low only during reset. Synchronous reset empties the pipeline and
// returns both registers to reset values (century byte off, current year 2024).
module rtc_fields_to_epoch_seconds
   import rtcep_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   start,
   output logic                   busy,
   input  logic [RAW_W-1:0]       req_raw_second,
   input  logic [RAW_W-1:0]       req_raw_minute,
   input  logic [RAW_W-1:0]       req_raw_hour,
   input  logic [RAW_W-1:0]       req_raw_day,
   input  logic [RAW_W-1:0]       req_raw_month,
   input  logic [RAW_W-1:0]       req_raw_year,
   input  logic [RAW_W-1:0]       req_raw_century,
   input  logic [RAW_W-1:0]       req_status_b,

   output logic                   rsp_valid,
   output logic [EPOCH_W-1:0]     rsp_epoch_seconds,
   output logic [YEAR_W-1:0]      rsp_full_year,
   output logic                   rsp_invalid,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CUR_YEAR_W-1:0]  csr_data
);

   // Configuration registers. The century of the current year is kept alongside
   // it so that the window needs no divide in the request path.
   logic                  century_in_use_ff;
   logic [CUR_YEAR_W-1:0] cur_year_ff;
   logic [CENT_W-1:0]     cur_cent_ff;
   logic [CENT_W-1:0]     cur_cent_in;
   logic [26:0]           cur_cent_prod;

   logic                  req_accept;
   logic                  csr_accept;

   // Stage 1: decoded fields and the four digit year.
   logic                  s1_valid_ff;
   logic [RAW_W-1:0]      s1_sec_ff, s1_min_ff, s1_hour_ff, s1_day_ff, s1_mon_ff;
   logic [YEAR_W-1:0]     s1_year_ff;
   logic [RAW_W-1:0]      s1_sec_in, s1_min_in, s1_hour_in, s1_day_in, s1_mon_in;
   logic [YEAR_W-1:0]     s1_year_in;
   logic [RAW_W-1:0]      yr_dec, cen_dec, hour_dec;
   logic [YEAR_W-1:0]     window_year;
   logic                  binary_mode;

   // Stage 2: whole year days, century quotient, time of day.
   logic                  s2_valid_ff;
   logic [DAYS_W-1:0]     s2_yday_ff;
   logic [FRAC_W-1:0]     s2_frac_ff;
   logic [QCENT_W-1:0]    s2_qcent_ff;
   logic [YEAR_W-1:0]     s2_year_ff;
   logic [RAW_W-1:0]      s2_mon_ff, s2_day_ff;
   logic [HMS_W-1:0]      s2_hms_ff;
   logic                  s2_bad_ff;
   logic [YEAR_W-1:0]     year_count;
   logic [42:0]           frac_prod;
   logic [27:0]           qcent_prod;
   logic [HMS_W-1:0]      s2_hms_in;
   logic                  s2_bad_in;

   // Stage 3: total day count.
   logic                  s3_valid_ff;
   logic [DAYS_W-1:0]     s3_days_ff;
   logic [DAYS_W-1:0]     s3_days_in;
   logic [HMS_W-1:0]      s3_hms_ff;
   logic [YEAR_W-1:0]     s3_year_ff;
   logic                  s3_bad_ff;
   logic [YEAR_W-1:0]     year_rem100;
   logic                  leap_year;
   logic [MDAYS_W-1:0]    month_days;

   // Stage 4: days in seconds.
   logic                  s4_valid_ff;
   logic [EPOCH_W-1:0]    s4_dsec_ff;
   logic [40:0]           dsec_prod;
   logic [HMS_W-1:0]      s4_hms_ff;
   logic [YEAR_W-1:0]     s4_year_ff;
   logic                  s4_bad_ff;

   // Output registers.
   logic                  rsp_valid_ff;
   logic [EPOCH_W-1:0]    rsp_epoch_ff;
   logic [EPOCH_W-1:0]    rsp_epoch_in;
   logic [YEAR_W-1:0]     rsp_year_ff;
   logic                  rsp_invalid_ff;

   assign busy       = reset;
   assign csr_ready  = ~reset;
   assign req_accept = start && !busy;
   assign csr_accept = csr_valid && csr_ready;

   // ---------------------------------------------------------------- config
   assign cur_cent_prod = 27'(csr_data) * 27'(DIV100_MUL);
   assign cur_cent_in   = cur_cent_prod[DIV100_SHIFT +: CENT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         century_in_use_ff <= 1'b0;
         cur_year_ff       <= CUR_YEAR_RESET;
         cur_cent_ff       <= CUR_CENT_RESET;
      end else if (csr_accept) begin
         unique case (csr_index)
            CSR_CENTURY_IN_USE: begin
               century_in_use_ff <= csr_data[0];
            end
            CSR_CUR_YEAR: begin
               cur_year_ff <= csr_data;
               cur_cent_ff <= cur_cent_in;
            end
            default: begin
            end
         endcase
      end
   end

   // --------------------------------------------------------------- stage 1
   always_comb begin
      binary_mode = req_status_b[STB_BINARY_BIT];
      if (binary_mode) begin
         s1_sec_in = req_raw_second;
         s1_min_in = req_raw_minute;
         hour_dec  = req_raw_hour;
         s1_day_in = req_raw_day;
         s1_mon_in = req_raw_month;
         yr_dec    = req_raw_year;
         cen_dec   = req_raw_century;
      end else begin
         s1_sec_in = bcd8(req_raw_second);
         s1_min_in = bcd8(req_raw_minute);
         hour_dec  = bcd_hour(req_raw_hour);
         s1_day_in = bcd8(req_raw_day);
         s1_mon_in = bcd8(req_raw_month);
         yr_dec    = bcd8(req_raw_year);
         cen_dec   = bcd8(req_raw_century);
      end

      // A PM hour in 12 hour mode moves on by twelve, modulo a day.
      if (!req_status_b[STB_24H_BIT] && hour_dec[HOUR_PM_BIT]) begin
         s1_hour_in = mod24(RAW_W'(hour_dec[6:0]) + 8'd12);
      end else begin
         s1_hour_in = hour_dec;
      end

      // Without a century byte the two digit year is placed in the century
      // of the current year, or the next one if that lands before it.
      window_year = YEAR_W'(cur_cent_ff) * 15'd100 + YEAR_W'(yr_dec);
      if (window_year < YEAR_W'(cur_year_ff)) begin
         window_year = window_year + 15'd100;
      end

      if (century_in_use_ff) begin
         s1_year_in = YEAR_W'(yr_dec) + YEAR_W'(cen_dec) * 15'd100;
      end else begin
         s1_year_in = window_year;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_accept;
      end
      s1_sec_ff  <= s1_sec_in;
      s1_min_ff  <= s1_min_in;
      s1_hour_ff <= s1_hour_in;
      s1_day_ff  <= s1_day_in;
      s1_mon_ff  <= s1_mon_in;
      s1_year_ff <= s1_year_in;
   end

   // --------------------------------------------------------------- stage 2
   // Whole years give year_count * 365 plus floor(year_count * 0.2422) days.
   // When the year is below 1970 year_count wraps, but the result is then
   // forced to zero anyway.
   assign year_count = s1_year_ff - EPOCH_YEAR;
   assign frac_prod  = 43'(year_count) * 43'(YEAR_FRAC_MUL);
   assign qcent_prod = 28'(s1_year_ff) * 28'(DIV100_MUL);
   assign s2_hms_in  = HMS_W'(s1_hour_ff) * 20'd3600 + HMS_W'(s1_min_ff) * 20'd60
                     + HMS_W'(s1_sec_ff);
   assign s2_bad_in  = (s1_year_ff < EPOCH_YEAR) || (s1_day_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_yday_ff  <= DAYS_W'(year_count) * DAYS_PER_YEAR;
      s2_frac_ff  <= frac_prod[YEAR_FRAC_SHIFT +: FRAC_W];
      s2_qcent_ff <= qcent_prod[DIV100_SHIFT +: QCENT_W];
      s2_year_ff  <= s1_year_ff;
      s2_mon_ff   <= s1_mon_ff;
      s2_day_ff   <= s1_day_ff;
      s2_hms_ff   <= s2_hms_in;
      s2_bad_ff   <= s2_bad_in;
   end

   // --------------------------------------------------------------- stage 3
   // Gregorian leap year: divisible by 4, and either not by 100 or by 400.
   // A year divisible by 100 is divisible by 400 when its century is by 4.
   always_comb begin
      year_rem100 = s2_year_ff - YEAR_W'(s2_qcent_ff) * 15'd100;
      leap_year   = (s2_year_ff[1:0] == 2'b00)
                 && ((year_rem100 != '0) || (s2_qcent_ff[1:0] == 2'b00));
      if ((s2_mon_ff >= 8'd2) && (s2_mon_ff <= 8'd12)) begin
         month_days = cum_days(s2_mon_ff[3:0])
                    + MDAYS_W'((s2_mon_ff >= 8'd3) && leap_year);
      end else begin
         month_days = '0;
      end
      s3_days_in = s2_yday_ff + DAYS_W'(s2_frac_ff) + DAYS_W'(month_days)
                 + DAYS_W'(s2_day_ff) - 24'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_days_ff <= s3_days_in;
      s3_hms_ff  <= s2_hms_ff;
      s3_year_ff <= s2_year_ff;
      s3_bad_ff  <= s2_bad_ff;
   end

   // --------------------------------------------------------------- stage 4
   assign dsec_prod = 41'(s3_days_ff) * 41'(SEC_PER_DAY);

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
      s4_dsec_ff <= dsec_prod[EPOCH_W-1:0];
      s4_hms_ff  <= s3_hms_ff;
      s4_year_ff <= s3_year_ff;
      s4_bad_ff  <= s3_bad_ff;
   end

   // ---------------------------------------------------------------- output
   // An invalid snapshot reports zero seconds but still carries its year.
   assign rsp_epoch_in = s4_bad_ff ? '0 : (s4_dsec_ff + EPOCH_W'(s4_hms_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s4_valid_ff;
      end
      rsp_epoch_ff   <= rsp_epoch_in;
      rsp_year_ff    <= s4_year_ff;
      rsp_invalid_ff <= s4_bad_ff;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_epoch_seconds = rsp_epoch_ff;
   assign rsp_full_year     = rsp_year_ff;
   assign rsp_invalid       = rsp_invalid_ff;

endmodule

FILE: hw/rtl/rtcep_checker.sv
// Port level checks for the RTC snapshot to epoch converter, bound to the top level.
module rtcep_checker
   import rtcep_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic [EPOCH_W-1:0] rsp_epoch_seconds,
   input logic [YEAR_W-1:0]  rsp_full_year,
   input logic               rsp_invalid
);

   // Every accepted request gives a result after the fixed pipeline latency.
   a_req_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LATENCY rsp_valid)
      else $error("accepted request produced no result");

   // No result appears without a request accepted at the matching edge.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result without a matching request");

   // An invalid snapshot always reports zero seconds.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid) |-> (rsp_epoch_seconds == '0))
      else $error("invalid result with nonzero seconds");

   // A valid result never has a year before the epoch.
   a_valid_year: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_invalid) |-> (rsp_full_year >= EPOCH_YEAR))
      else $error("valid result with a year before 1970");

   // Reset empties the pipeline.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

endmodule

bind rtc_fields_to_epoch_seconds rtcep_checker u_rtcep_checker (.*);
